FILE: rtl/core/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache core.
// No dependencies; used by lkvc_cell and lru_key_value_cache_core.
package lkvc_pkg;

  // Update applied by every cell in the update cycle
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,  // no change (get miss or no item)
    MODE_HIT   = 2'd1,  // key found: touch matching cell
    MODE_EVICT = 2'd2,  // new key, cache full: replace least recent
    MODE_FILL  = 2'd3   // new key, free slot: fill lowest free cell
  } mode_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Control broadcast from the sequencer to the cell row
  typedef struct packed {
    logic  load;    // item accepted: latch key match
    mode_t mode;    // update kind
    logic  is_put;  // overwrite data on hit
  } cell_ctl_t;

  localparam logic       CMD_GET    = 1'b0;
  localparam logic       CMD_PUT    = 1'b1;
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [4:0] CAP_RESET  = 5'd16;

endpackage

FILE: rtl/core/lkvc_cell.sv
// One cache entry: valid, key, data, recency rank and a latched key match.
// Depends on lkvc_pkg; chained left to right by lru_key_value_cache_core.
module lkvc_cell #(
  parameter int RW = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lkvc_pkg::cell_ctl_t ctl,
  input  logic [31:0]         lookup_key,
  input  logic [31:0]         wr_key,
  input  logic [31:0]         wr_value,
  input  logic [RW-1:0]       touch_rank,
  input  logic                hit_i,
  input  logic [31:0]         data_i,
  input  logic [RW-1:0]       rank_i,
  input  logic                free_i,
  output logic                hit_o,
  output logic [31:0]         data_o,
  output logic [RW-1:0]       rank_o,
  output logic                free_o
);

  logic          valid_r, valid_nxt;
  logic [31:0]   key_r, key_nxt;
  logic [31:0]   data_r, data_nxt;
  logic [RW-1:0] rank_r, rank_nxt;
  logic          match_r, match_nxt;

  // Chain: pass hit data/rank along, note whether a free cell was seen
  assign hit_o  = hit_i | match_r;
  assign data_o = data_i | (match_r ? data_r : '0);
  assign rank_o = rank_i | (match_r ? rank_r : '0);
  assign free_o = free_i | ~valid_r;

  // Entry update
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    data_nxt  = data_r;
    rank_nxt  = rank_r;
    match_nxt = match_r;
    if (ctl.load) begin
      match_nxt = valid_r && (key_r == lookup_key);
    end
    case (ctl.mode)
      lkvc_pkg::MODE_HIT: begin
        if (match_r) begin
          rank_nxt = '0;
          if (ctl.is_put) begin
            data_nxt = wr_value;
          end
        end else if (valid_r && (rank_r < touch_rank)) begin
          rank_nxt = rank_r + RW'(1);
        end
      end
      lkvc_pkg::MODE_EVICT: begin
        if (valid_r && (rank_r == touch_rank)) begin
          key_nxt  = wr_key;
          data_nxt = wr_value;
          rank_nxt = '0;
        end else if (valid_r && (rank_r < touch_rank)) begin
          rank_nxt = rank_r + RW'(1);
        end
      end
      lkvc_pkg::MODE_FILL: begin
        if (!valid_r && !free_i) begin
          valid_nxt = 1'b1;
          key_nxt   = wr_key;
          data_nxt  = wr_value;
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + RW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    data_r <= data_nxt;
  end

endmodule

FILE: rtl/core/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key-value cache: sequencer,
// APB capacity register and a row of lkvc_cell. Depends on lkvc_pkg.
//
// Usage:
//   Input channel: an item (in_cmd, in_key, in_value) is taken at a clock
//   edge with start high and busy low. cmd get looks a key up, cmd put
//   inserts or updates it.
//   Result channel: each get gives one item on out_hit/out_read_value with
//   out_strobe high for exactly one cycle; a put gives none. On a miss
//   out_read_value is all ones. The receiver cannot stall the block.
//   Timing: no item is taken while busy. At the accept edge every cell compares
//   in_key against its entry; in the next cycle (busy high) the match ripples
//   through the cell row, ranks and entries update, and the result register
//   loads, so out_strobe rises the cycle after busy. A new item may be
//   accepted while that result is on the ports.
//   Configuration: capacity at byte address 0 of the APB port, written only
//   while idle; 0 acts as 1, above ENTRIES acts as ENTRIES. Reset value 16.
//   Reset (rst_n low, synchronous): all entries invalid, ranks and occupancy
//   zero, capacity 16, no result pending.
module lru_key_value_cache_core #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_strobe,
  output logic        out_hit,
  output logic [31:0] out_read_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (OW > 5) ? OW : 5;

  lkvc_pkg::state_t    state_r, state_nxt;
  logic                cmd_r;
  logic [31:0]         key_r, value_r;
  logic [OW-1:0]       occ_r, occ_nxt;
  logic [4:0]          cap_r;
  logic                out_strobe_r, out_strobe_nxt;
  logic                out_hit_r, out_hit_nxt;
  logic [31:0]         out_value_r, out_value_nxt;
  logic                accept;
  lkvc_pkg::cell_ctl_t ctl;
  logic [RW-1:0]       touch_rank;
  logic [CMPW-1:0]     eff_cap;

  // Cell row chain wires
  logic                hit_c  [ENTRIES+1];
  logic [31:0]         data_c [ENTRIES+1];
  logic [RW-1:0]       rank_c [ENTRIES+1];
  logic                free_c [ENTRIES+1];

  assign accept = start && (state_r == lkvc_pkg::ST_IDLE);
  assign busy   = (state_r == lkvc_pkg::ST_EXEC);

  // APB capacity register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkvc_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      cap_r <= pwdata[4:0];
    end
  end

  // Effective capacity, clamped to 1..ENTRIES
  always_comb begin
    if (cap_r == 5'd0) begin
      eff_cap = CMPW'(1);
    end else if (CMPW'(cap_r) > CMPW'(ENTRIES)) begin
      eff_cap = CMPW'(ENTRIES);
    end else begin
      eff_cap = CMPW'(cap_r);
    end
  end

  // Item hold registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_cmd;
      key_r   <= in_key;
      value_r <= in_value;
    end
  end

  // Sequencer: next state, cell update mode, result
  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    out_strobe_nxt = 1'b0;
    out_hit_nxt    = out_hit_r;
    out_value_nxt  = out_value_r;
    ctl.load       = accept;
    ctl.mode       = lkvc_pkg::MODE_IDLE;
    ctl.is_put     = (cmd_r == lkvc_pkg::CMD_PUT);
    touch_rank     = rank_c[ENTRIES];
    case (state_r)
      lkvc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = lkvc_pkg::ST_EXEC;
        end
      end
      lkvc_pkg::ST_EXEC: begin
        state_nxt = lkvc_pkg::ST_IDLE;
        if (hit_c[ENTRIES]) begin
          ctl.mode = lkvc_pkg::MODE_HIT;
        end else if (cmd_r == lkvc_pkg::CMD_PUT) begin
          if (CMPW'(occ_r) >= eff_cap) begin
            ctl.mode   = lkvc_pkg::MODE_EVICT;
            touch_rank = RW'(occ_r - OW'(1));
          end else begin
            ctl.mode = lkvc_pkg::MODE_FILL;
            occ_nxt  = occ_r + OW'(1);
          end
        end
        if (cmd_r == lkvc_pkg::CMD_GET) begin
          out_strobe_nxt = 1'b1;
          out_hit_nxt    = hit_c[ENTRIES];
          out_value_nxt  = hit_c[ENTRIES] ? data_c[ENTRIES] : lkvc_pkg::MISS_VALUE;
        end
      end
      default: begin
        state_nxt = lkvc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lkvc_pkg::ST_IDLE;
      occ_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r   <= out_hit_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_strobe     = out_strobe_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_value_r;

  // Cell row
  assign hit_c[0]  = 1'b0;
  assign data_c[0] = '0;
  assign rank_c[0] = '0;
  assign free_c[0] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkvc_cell #(
      .RW (RW)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .lookup_key (in_key),
      .wr_key     (key_r),
      .wr_value   (value_r),
      .touch_rank (touch_rank),
      .hit_i      (hit_c[i]),
      .data_i     (data_c[i]),
      .rank_i     (rank_c[i]),
      .free_i     (free_c[i]),
      .hit_o      (hit_c[i+1]),
      .data_o     (data_c[i+1]),
      .rank_o     (rank_c[i+1]),
      .free_o     (free_c[i+1])
    );
  end

endmodule

FILE: rtl/core/lkvc_checker.sv
// Port-level checks for lru_key_value_cache_core, bound to the top level.
// Depends only on the top level's ports.
module lkvc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input logic        out_hit,
  input logic [31:0] out_read_value,
  input logic        pready
);

  // An accepted item occupies exactly one busy cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_busy_one: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // A result only follows a busy cycle
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a preceding busy cycle");

  // Miss reports all ones
  a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_hit) |-> (out_read_value == 32'hFFFF_FFFF))
    else $error("miss result not all ones");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("pready low");

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_hit        (out_hit),
  .out_read_value (out_read_value),
  .pready         (pready)
);

FILE: tb/sv/lru_cache_lookup_check.sv
`timescale 1ns / 100ps
// Result checker for lru_key_value_cache_core: tracks items, results and APB writes,
// keeps its own LRU cache state and compares every get answer in order.
// Depends on lkvc_pkg; instantiated next to the block by lru_key_value_cache_core_tb.
module lru_cache_lookup_check #(
  parameter int         ENTRIES  = 16,
  parameter logic [2:0] CAP_ADDR = 3'd0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_cmd,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  input  logic        out_strobe,
  input  logic        out_hit,
  input  logic [31:0] out_read_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatch_count,
  output int          lookups_due
);

  typedef struct packed {
    logic        hit;
    logic [31:0] data;
  } lookup_t;

  // Shadow copy of the cache
  logic        slot_valid [ENTRIES];
  logic [31:0] slot_key   [ENTRIES];
  logic [31:0] slot_data  [ENTRIES];
  logic [3:0]  slot_rank  [ENTRIES];
  logic [4:0]  fill_count;
  logic [4:0]  capacity;

  lookup_t lookups_q[$];
  int      err_total = 0;

  initial begin
    mismatch_count = 0;
    lookups_due    = 0;
  end

  // Capacity as the block applies it: 0 acts as 1, above ENTRIES as ENTRIES
  function automatic int unsigned cap_limit();
    if (capacity == 0) return 1;
    if (capacity > ENTRIES) return ENTRIES;
    return 32'(capacity);
  endfunction

  // Slot s becomes most recent; entries that were more recent age by one
  function automatic void make_recent(int s);
    logic [3:0] r;
    r = slot_rank[s];
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
    slot_rank[s] = '0;
  endfunction

  // Apply one item to the shadow cache; a get produces a lookup answer
  function automatic void cache_access(input logic cmd, input logic [31:0] key,
                                       input logic [31:0] value,
                                       output bit answers, output lookup_t res);
    int slot;
    int victim;
    slot    = -1;
    victim  = -1;
    answers = 1'b0;
    res     = '0;
    for (int i = 0; i < ENTRIES; i++)
      if (slot < 0 && slot_valid[i] && slot_key[i] == key) slot = i;

    if (cmd == lkvc_pkg::CMD_GET) begin
      answers = 1'b1;
      if (slot >= 0) begin
        res.hit  = 1'b1;
        res.data = slot_data[slot];
        make_recent(slot);
      end else begin
        res.hit  = 1'b0;
        res.data = lkvc_pkg::MISS_VALUE;
      end
    end else if (slot >= 0) begin
      // update in place
      slot_data[slot] = value;
      make_recent(slot);
    end else if (fill_count >= cap_limit()) begin
      // full (or capacity lowered below occupancy): replace the least recent
      for (int i = 0; i < ENTRIES; i++)
        if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
      slot_key[victim]  = key;
      slot_data[victim] = value;
      make_recent(victim);
    end else begin
      // lowest free slot, everything else ages
      for (int i = 0; i < ENTRIES; i++)
        if (victim < 0 && !slot_valid[i]) victim = i;
      for (int i = 0; i < ENTRIES; i++)
        if (slot_valid[i]) slot_rank[i]++;
      slot_valid[victim] = 1'b1;
      slot_key[victim]   = key;
      slot_data[victim]  = value;
      slot_rank[victim]  = '0;
      fill_count++;
    end
  endfunction

  task automatic note_error(input string what);
    err_total++;
    if (err_total <= 10) $display("[%0t] lookup mismatch: %s", $time, what);
  endtask

  // Everything is sampled on the rising edge
  always @(posedge clk) begin : watch
    lookup_t got;
    lookup_t want;
    bit      answers;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
        slot_rank[i]  = '0;
      end
      fill_count = '0;
      capacity   = lkvc_pkg::CAP_RESET;
      lookups_q.delete();
    end else begin
      if (out_strobe) begin
        got = {out_hit, out_read_value};
        if (lookups_q.size() == 0) begin
          note_error($sformatf("result with no get waiting: hit %b value %h",
                               got.hit, got.data));
        end else begin
          want = lookups_q.pop_front();
          if (got.hit !== want.hit || got.data !== want.data)
            note_error($sformatf("expected hit %b value %h, got hit %b value %h",
                                 want.hit, want.data, got.hit, got.data));
        end
      end
      // register index is the word address
      if (psel && penable && pwrite && pready && paddr[2] == CAP_ADDR[2])
        capacity = pwdata[4:0];
      if (start && !busy) begin
        cache_access(in_cmd, in_key, in_value, answers, want);
        if (answers) lookups_q.push_back(want);
      end
    end
    lookups_due    <= lookups_q.size();
    mismatch_count <= err_total;
  end

endmodule

FILE: tb/sv/lru_key_value_cache_core_tb.sv
`timescale 1ns / 100ps
// Testbench top for lru_key_value_cache_core: clock, reset, item and APB stimulus,
// idle watchdog and verdict. Depends on lkvc_pkg and lru_cache_lookup_check.
module lru_key_value_cache_core_tb;

  localparam int          ENTRIES      = 16;
  localparam logic [2:0]  CAP_ADDR     = 3'd0;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          PHASES       = 9;
  localparam int          PHASE_ITEMS  = 212;
  localparam int          STEADY_PHASE = 3;
  localparam int          POOL_MAX     = 24;
  localparam logic [31:0] KEY_MIN      = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] KEY_ONES     = 32'hFFFF_FFFF;
  localparam logic [31:0] KEY_ZERO     = 32'h0000_0000;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        start    = 1'b0;
  logic        in_cmd   = lkvc_pkg::CMD_GET;
  logic [31:0] in_key   = '0;
  logic [31:0] in_value = '0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;

  logic        busy;
  logic        out_strobe;
  logic        out_hit;
  logic [31:0] out_read_value;
  logic [31:0] prdata;
  logic        pready;

  int mismatch_count;
  int lookups_due;
  bit steady = 1'b0;  // no sender gaps while set

  // Per-phase capacity and size of the key working set
  logic [4:0]  phase_caps [PHASES] = '{5'd4, 5'd1, 5'd8, 5'd31, 5'd17, 5'd16, 5'd0, 5'd12,
                                       5'd23};
  int          pool_sizes [PHASES] = '{6, 3, 10, 20, 18, 24, 5, 14, 16};
  logic [31:0] key_pool   [POOL_MAX];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  lru_key_value_cache_core #(.ENTRIES(ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_key(in_key), .in_value(in_value),
    .out_strobe(out_strobe), .out_hit(out_hit), .out_read_value(out_read_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lru_cache_lookup_check #(.ENTRIES(ENTRIES), .CAP_ADDR(CAP_ADDR)) lookup_check (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_key(in_key), .in_value(in_value),
    .out_strobe(out_strobe), .out_hit(out_hit), .out_read_value(out_read_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .mismatch_count(mismatch_count), .lookups_due(lookups_due)
  );

  // One item: optional random gap, then hold start until the block takes it
  task automatic send_item(input logic cmd, input logic [31:0] key, input logic [31:0] value);
    int gap;
    @(negedge clk);
    if (!steady && $urandom_range(99) < 35) begin
      gap = $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start    <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    in_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Capacity write once the block has drained; upper data bits are noise
  task automatic write_capacity(input logic [4:0] cap);
    logic [31:0] word;
    word      = $urandom();
    word[4:0] = cap;
    @(negedge clk);
    start <= 1'b0;
    while (lookups_due != 0 || busy) @(negedge clk);
    // a trailing put may still be in flight
    repeat (4) @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= CAP_ADDR;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin : stimulus
    logic [31:0] key;
    int          sel;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Empty cache misses
    send_item(lkvc_pkg::CMD_GET, KEY_ZERO, KEY_ONES);

    // Capacity zero behaves as one: second put evicts the first
    write_capacity(5'd0);
    send_item(lkvc_pkg::CMD_PUT, KEY_MIN, KEY_MAX);
    send_item(lkvc_pkg::CMD_PUT, KEY_MAX, KEY_MIN);
    send_item(lkvc_pkg::CMD_GET, KEY_MIN, KEY_ZERO);
    send_item(lkvc_pkg::CMD_GET, KEY_MAX, KEY_ZERO);

    // Capacity 3: fill, stored all-ones value, LRU eviction, overwrite
    write_capacity(5'd3);
    send_item(lkvc_pkg::CMD_PUT, KEY_ZERO, KEY_ZERO);
    send_item(lkvc_pkg::CMD_PUT, KEY_ONES, KEY_ONES);
    send_item(lkvc_pkg::CMD_GET, KEY_ONES, KEY_ZERO);
    send_item(lkvc_pkg::CMD_PUT, 32'h0000_0001, 32'h1234_5678);
    send_item(lkvc_pkg::CMD_GET, KEY_MAX, KEY_ZERO);
    send_item(lkvc_pkg::CMD_GET, KEY_ZERO, KEY_ONES);
    send_item(lkvc_pkg::CMD_PUT, KEY_ZERO, 32'hA5A5_5A5A);
    send_item(lkvc_pkg::CMD_PUT, 32'h5555_AAAA, 32'h0F0F_F0F0);
    send_item(lkvc_pkg::CMD_GET, KEY_ONES, KEY_ZERO);
    send_item(lkvc_pkg::CMD_GET, KEY_ZERO, KEY_ZERO);

    // Capacity lowered below occupancy: new keys replace, nothing shrinks
    write_capacity(5'd2);
    send_item(lkvc_pkg::CMD_PUT, KEY_ONES, KEY_MAX);
    send_item(lkvc_pkg::CMD_GET, 32'h0000_0001, KEY_ZERO);
    send_item(lkvc_pkg::CMD_GET, 32'h5555_AAAA, KEY_ZERO);
    send_item(lkvc_pkg::CMD_GET, KEY_ONES, KEY_ZERO);
    send_item(lkvc_pkg::CMD_PUT, KEY_MIN, KEY_ZERO);
    send_item(lkvc_pkg::CMD_GET, KEY_ZERO, KEY_ZERO);

    // Random phases over a working set of keys, capacity changed in between
    for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom();
    for (int p = 0; p < PHASES; p++) begin
      write_capacity(phase_caps[p]);
      steady = (p == STEADY_PHASE);
      for (int i = 0; i < POOL_MAX; i++)
        if ($urandom_range(1) == 1) key_pool[i] = $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(99);
        if (sel < 80) begin
          key = key_pool[$urandom_range(pool_sizes[p] - 1)];
        end else if (sel < 86) begin
          case ($urandom_range(3))
            0:       key = KEY_MIN;
            1:       key = KEY_MAX;
            2:       key = KEY_ONES;
            default: key = KEY_ZERO;
          endcase
        end else begin
          key = $urandom();
        end
        send_item(($urandom_range(99) < 45) ? lkvc_pkg::CMD_PUT : lkvc_pkg::CMD_GET,
                  key, $urandom());
      end
    end

    // Drain and settle
    @(negedge clk);
    start <= 1'b0;
    while (lookups_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("lru_key_value_cache_core_tb: done, clean");
    end else begin
      $display("lru_key_value_cache_core_tb: done, errors");
    end
    $finish;
  end

  // Ends a hung run: too many cycles with nothing accepted on any channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_strobe || (psel && penable && pwrite && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("lru_key_value_cache_core_tb: done, errors");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_cell.sv
rtl/core/lru_key_value_cache_core.sv
rtl/core/lkvc_checker.sv
tb/sv/lru_cache_lookup_check.sv
tb/sv/lru_key_value_cache_core_tb.sv
